@@ design/lru_k_frame_replacer_assert.svh @@
// Assertion macros used by the port checker of the LRU-K replacer.
// No dependencies; each macro expects a clock and an active-high reset.
`ifndef LRU_K_FRAME_REPLACER_ASSERT_SVH
`define LRU_K_FRAME_REPLACER_ASSERT_SVH

// Same-cycle implication, reset masks the check.
`define LKR_ASSERT_IMPLY(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("lkr: implication violated");

// Next-cycle implication, reset masks the check.
`define LKR_ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("lkr: next-cycle implication violated");

`endif

@@ design/lkr_pkg.sv @@
// Shared types and constants of the LRU-K frame replacer.
// No dependencies; used by every other file of the block but the assertion header.
`timescale 1ns / 1ps
package lkr_pkg;

  localparam int FRAME_SLOTS_DEF   = 64;
  localparam int HISTORY_DEPTH_DEF = 4;
  localparam int STAMP_BITS_DEF    = 32;

  localparam int MODE_BITS      = 2;
  localparam int FRAME_BITS     = 8;
  localparam int STATUS_BITS    = 3;
  localparam int VICTIM_BITS    = 6;
  localparam int COUNT_OUT_BITS = 7;
  localparam int CFG_BITS       = 7;
  localparam int APB_ADDR_BITS  = 3;
  localparam int APB_DATA_BITS  = 32;

  localparam logic [CFG_BITS-1:0]      FRAMES_IN_USE_RST = 7'd64;
  localparam logic [APB_ADDR_BITS-1:0] REG_FRAMES_IN_USE = 3'd0;

  typedef enum logic [MODE_BITS-1:0] {
    MODE_ACCESS        = 2'd0,
    MODE_SET_EVICTABLE = 2'd1,
    MODE_EVICT         = 2'd2,
    MODE_REMOVE        = 2'd3
  } mode_t;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK            = 3'd0,
    ST_RANGE         = 3'd1,
    ST_UNTRACKED     = 3'd2,
    ST_NOT_EVICTABLE = 3'd3,
    ST_NOTHING       = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_EXEC,
    S_SCAN,
    S_DRAIN,
    S_FINISH,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic latch;
    logic exec;
    logic scan_clear;
    logic scan_step;
    logic finish;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic is_evict;
    logic scan_last;
    logic out_free;
  } stat_t;

endpackage

@@ design/lkr_ifs.sv @@
// Valid/ready channel interfaces for event items and result items.
// Depends on lkr_pkg for field widths.
`timescale 1ns / 1ps
interface lkr_item_if;
  import lkr_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [MODE_BITS-1:0]  mode;
  logic [FRAME_BITS-1:0] frame;
  logic                  evictable_flag;
  modport source (output valid, mode, frame, evictable_flag, input ready);
  modport sink   (input valid, mode, frame, evictable_flag, output ready);
endinterface

interface lkr_result_if;
  import lkr_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [STATUS_BITS-1:0]    status;
  logic [VICTIM_BITS-1:0]    victim_frame;
  logic [COUNT_OUT_BITS-1:0] evictable_count;
  modport source (output valid, status, victim_frame, evictable_count, input ready);
  modport sink   (input valid, status, victim_frame, evictable_count, output ready);
endinterface

@@ design/lru_k_frame_replacer.sv @@
// LRU-K frame replacer. Each item on req is one event (access, set
// evictable, evict, remove) and gives exactly one item on rsp. Access,
// set evictable and remove go from acceptance through dispatch and
// execute to the result register. Evict goes through dispatch, a scan
// over all FRAME_SLOTS frames that reads one oldest stamp per frame per
// cycle through the single read port of the stamp memory, then drain and
// finish to the result register. One item is worked on at a time; a new
// item is accepted while the previous result still waits on rsp. Depends
// on lkr_pkg, lkr_ifs, lkr_cfg_regs, lkr_ctrl and lkr_datapath.
`timescale 1ns / 1ps
module lru_k_frame_replacer #(
  parameter int FRAME_SLOTS   = lkr_pkg::FRAME_SLOTS_DEF,
  parameter int HISTORY_DEPTH = lkr_pkg::HISTORY_DEPTH_DEF,
  parameter int STAMP_BITS    = lkr_pkg::STAMP_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  lkr_item_if.sink                          req,
  lkr_result_if.source                      rsp,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [lkr_pkg::APB_ADDR_BITS-1:0] paddr,
  input  logic [lkr_pkg::APB_DATA_BITS-1:0] pwdata,
  output logic [lkr_pkg::APB_DATA_BITS-1:0] prdata,
  output logic                              pready
);
  import lkr_pkg::*;

  cmd_t                cmd;
  stat_t               stat;
  logic [CFG_BITS-1:0] frames_in_use;

  // Limit register; the user must write it only while the block is idle, the block itself does not enforce this
  lkr_cfg_regs u_cfg (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .frames_in_use (frames_in_use)
  );

  // Sequence each item: latch, decode, execute or scan, hand off
  lkr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Hold frame state and stamps; the result register parts rsp from the work
  lkr_datapath #(
    .FRAME_SLOTS   (FRAME_SLOTS),
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .STAMP_BITS    (STAMP_BITS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .frames_in_use   (frames_in_use),
    .mode            (req.mode),
    .frame           (req.frame),
    .evictable_flag  (req.evictable_flag),
    .out_valid       (rsp.valid),
    .out_ready       (rsp.ready),
    .status          (rsp.status),
    .victim_frame    (rsp.victim_frame),
    .evictable_count (rsp.evictable_count)
  );

endmodule

@@ design/lkr_cfg_regs.sv @@
// APB-style register file holding the frames_in_use limit.
// Depends on lkr_pkg.
`timescale 1ns / 1ps
module lkr_cfg_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [lkr_pkg::APB_ADDR_BITS-1:0]   paddr,
  input  logic [lkr_pkg::APB_DATA_BITS-1:0]   pwdata,
  output logic [lkr_pkg::APB_DATA_BITS-1:0]   prdata,
  output logic                                pready,
  output logic [lkr_pkg::CFG_BITS-1:0]        frames_in_use
);
  import lkr_pkg::*;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= FRAMES_IN_USE_RST;
    end else if (psel && penable && pwrite && paddr == REG_FRAMES_IN_USE) begin
      frames_in_use <= pwdata[CFG_BITS-1:0];
    end
  end

  assign prdata = (paddr == REG_FRAMES_IN_USE) ? APB_DATA_BITS'(frames_in_use) : '0;

endmodule

@@ design/lkr_ctrl.sv @@
// Sequencer of the LRU-K replacer: steps each item through decode,
// execute or victim scan, and result hand-off. Depends on lkr_pkg.
`timescale 1ns / 1ps
module lkr_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  lkr_pkg::stat_t stat,
  output lkr_pkg::cmd_t  cmd
);
  import lkr_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        cmd.scan_clear = 1'b1;
        state_next     = stat.is_evict ? S_SCAN : S_EXEC;
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = S_RESULT;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_last) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        state_next = S_FINISH;
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        state_next = S_RESULT;
      end
      S_RESULT: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

@@ design/lkr_datapath.sv @@
// Frame state, stamp memory, victim scan and result register of the
// LRU-K replacer. Depends on lkr_pkg; driven by lkr_ctrl commands.
`timescale 1ns / 1ps
module lkr_datapath #(
  parameter int FRAME_SLOTS   = lkr_pkg::FRAME_SLOTS_DEF,
  parameter int HISTORY_DEPTH = lkr_pkg::HISTORY_DEPTH_DEF,
  parameter int STAMP_BITS    = lkr_pkg::STAMP_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  lkr_pkg::cmd_t                        cmd,
  output lkr_pkg::stat_t                       stat,
  input  logic [lkr_pkg::CFG_BITS-1:0]         frames_in_use,
  input  logic [lkr_pkg::MODE_BITS-1:0]        mode,
  input  logic [lkr_pkg::FRAME_BITS-1:0]       frame,
  input  logic                                 evictable_flag,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [lkr_pkg::STATUS_BITS-1:0]      status,
  output logic [lkr_pkg::VICTIM_BITS-1:0]      victim_frame,
  output logic [lkr_pkg::COUNT_OUT_BITS-1:0]   evictable_count
);
  import lkr_pkg::*;

  localparam int FW    = $clog2(FRAME_SLOTS);
  localparam int SW    = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int HW    = $clog2(HISTORY_DEPTH + 1);
  localparam int DEPTH = FRAME_SLOTS * HISTORY_DEPTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int TW    = $clog2(FRAME_SLOTS + 1);
  localparam int LW    = (TW > CFG_BITS) ? TW : CFG_BITS;
  localparam int CW    = (LW > FRAME_BITS) ? LW : FRAME_BITS;

  // Latched item
  mode_t                 mode_q;
  logic [FRAME_BITS-1:0] frame_q;
  logic                  flag_q;

  // Per-frame state
  logic          tracked [FRAME_SLOTS];
  logic          evict   [FRAME_SLOTS];
  logic [HW-1:0] cnt     [FRAME_SLOTS];
  logic [SW-1:0] start   [FRAME_SLOTS];
  logic [STAMP_BITS-1:0] access_clock;
  logic [TW-1:0]         total;

  // Stamp memory
  logic [STAMP_BITS-1:0] mem [DEPTH];
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [AW-1:0]         mem_raddr;
  logic [STAMP_BITS-1:0] rd_data;

  // Scan pipeline and best candidates
  logic [FW-1:0]         idx;
  logic                  rd_v, rd_elig, rd_short;
  logic [FW-1:0]         rd_f;
  logic                  have_s, have_f;
  logic [FW-1:0]         best_s_f, best_f_f;
  logic [STAMP_BITS-1:0] best_s, best_f;

  // Result staging
  status_t       res_status;
  logic [FW-1:0] res_victim;

  logic [CW-1:0] limit;
  logic [CW-1:0] fr_ext;
  logic          in_range;
  logic [FW-1:0] fi;
  logic [SW-1:0] slot_sel;
  logic [SW-1:0] start_inc;
  logic          hist_full;
  logic [FW-1:0] victim;
  logic          have_any;

  assign fr_ext   = CW'(frame_q);
  assign limit    = (CW'(frames_in_use) < CW'(FRAME_SLOTS)) ? CW'(frames_in_use)
                                                            : CW'(FRAME_SLOTS);
  assign in_range = fr_ext < limit;
  assign fi       = FW'(fr_ext);

  assign hist_full = cnt[fi] >= HW'(HISTORY_DEPTH);
  assign slot_sel  = hist_full ? start[fi] : SW'(cnt[fi]);
  assign start_inc = (start[fi] == SW'(HISTORY_DEPTH - 1)) ? '0 : start[fi] + 1'b1;

  assign mem_we    = cmd.exec && mode_q == MODE_ACCESS && in_range;
  assign mem_waddr = AW'(fi) * AW'(HISTORY_DEPTH) + AW'(slot_sel);
  assign mem_raddr = AW'(idx) * AW'(HISTORY_DEPTH) + AW'(start[idx]);

  assign have_any = have_s || have_f;
  assign victim   = have_s ? best_s_f : best_f_f;

  assign stat.is_evict  = mode_q == MODE_EVICT;
  assign stat.scan_last = idx == FW'(FRAME_SLOTS - 1);
  assign stat.out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= access_clock;
    if (cmd.scan_step) rd_data <= mem[mem_raddr];
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      mode_q  <= mode_t'(mode);
      frame_q <= frame;
      flag_q  <= evictable_flag;
    end
    if (cmd.scan_step) begin
      rd_f     <= idx;
      rd_elig  <= tracked[idx] && evict[idx] && cnt[idx] != '0;
      rd_short <= cnt[idx] < HW'(HISTORY_DEPTH);
    end
    if (rd_v && rd_elig) begin
      if (rd_short && (!have_s || rd_data < best_s)) begin
        best_s   <= rd_data;
        best_s_f <= rd_f;
      end
      if (!rd_short && (!have_f || rd_data < best_f)) begin
        best_f   <= rd_data;
        best_f_f <= rd_f;
      end
    end
    if (cmd.load_out) begin
      status          <= res_status;
      victim_frame    <= VICTIM_BITS'(res_victim);
      evictable_count <= COUNT_OUT_BITS'(total);
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < FRAME_SLOTS; i++) begin
        tracked[i] <= 1'b0;
        evict[i]   <= 1'b0;
        cnt[i]     <= '0;
        start[i]   <= '0;
      end
      access_clock <= '0;
      total        <= '0;
      idx          <= '0;
      rd_v         <= 1'b0;
      have_s       <= 1'b0;
      have_f       <= 1'b0;
      out_valid    <= 1'b0;
      res_status   <= ST_OK;
      res_victim   <= '0;
    end else begin
      rd_v <= cmd.scan_step;
      if (cmd.scan_clear) begin
        idx    <= '0;
        have_s <= 1'b0;
        have_f <= 1'b0;
      end
      if (cmd.scan_step) idx <= idx + 1'b1;
      if (rd_v && rd_elig) begin
        if (rd_short && (!have_s || rd_data < best_s)) have_s <= 1'b1;
        if (!rd_short && (!have_f || rd_data < best_f)) have_f <= 1'b1;
      end

      if (cmd.exec) begin
        res_victim <= '0;
        if (!in_range) begin
          res_status <= ST_RANGE;
        end else begin
          case (mode_q)
            MODE_ACCESS: begin
              res_status  <= ST_OK;
              tracked[fi] <= 1'b1;
              if (hist_full) begin
                start[fi] <= start_inc;
              end else begin
                cnt[fi] <= cnt[fi] + 1'b1;
              end
              if (access_clock != '1) access_clock <= access_clock + 1'b1;
            end
            MODE_SET_EVICTABLE: begin
              if (!tracked[fi]) begin
                res_status <= ST_UNTRACKED;
              end else begin
                res_status <= ST_OK;
                if (evict[fi] != flag_q) begin
                  evict[fi] <= flag_q;
                  if (flag_q) total <= total + 1'b1;
                  else if (total != '0) total <= total - 1'b1;
                end
              end
            end
            MODE_REMOVE: begin
              if (!tracked[fi]) begin
                res_status <= ST_UNTRACKED;
              end else if (!evict[fi]) begin
                res_status <= ST_NOT_EVICTABLE;
              end else begin
                res_status  <= ST_OK;
                tracked[fi] <= 1'b0;
                evict[fi]   <= 1'b0;
                cnt[fi]     <= '0;
                start[fi]   <= '0;
                if (total != '0) total <= total - 1'b1;
              end
            end
            default: res_status <= ST_OK;
          endcase
        end
      end

      if (cmd.finish) begin
        if (have_any) begin
          res_status      <= ST_OK;
          res_victim      <= victim;
          tracked[victim] <= 1'b0;
          evict[victim]   <= 1'b0;
          cnt[victim]     <= '0;
          start[victim]   <= '0;
          if (evict[victim] && total != '0) total <= total - 1'b1;
        end else begin
          res_status <= ST_NOTHING;
          res_victim <= '0;
        end
      end

      if (cmd.load_out) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

@@ design/lkr_checker.sv @@
// Port-level checks of the LRU-K replacer, bound to the top level.
// Depends on lkr_pkg and lru_k_frame_replacer_assert.svh.
`timescale 1ns / 1ps
`include "lru_k_frame_replacer_assert.svh"
module lkr_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                req_valid,
  input logic                                req_ready,
  input logic                                rsp_valid,
  input logic                                rsp_ready,
  input logic [lkr_pkg::STATUS_BITS-1:0]     rsp_status,
  input logic [lkr_pkg::VICTIM_BITS-1:0]     rsp_victim_frame,
  input logic [lkr_pkg::COUNT_OUT_BITS-1:0]  rsp_evictable_count
);
  import lkr_pkg::*;

  `LKR_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_victim_frame) && $stable(rsp_evictable_count))
  `LKR_ASSERT_NEXT(a_one_at_a_time, clk, rst, req_valid && req_ready, !req_ready)
  `LKR_ASSERT_IMPLY(a_victim_ok, clk, rst, rsp_valid && rsp_victim_frame != '0, rsp_status == ST_OK)
  `LKR_ASSERT_IMPLY(a_nothing_empty, clk, rst, rsp_valid && rsp_status == ST_NOTHING, rsp_evictable_count == '0)

endmodule

bind lru_k_frame_replacer lkr_checker u_lkr_checker (
  .clk                 (clk),
  .rst                 (rst),
  .req_valid           (req.valid),
  .req_ready           (req.ready),
  .rsp_valid           (rsp.valid),
  .rsp_ready           (rsp.ready),
  .rsp_status          (rsp.status),
  .rsp_victim_frame    (rsp.victim_frame),
  .rsp_evictable_count (rsp.evictable_count)
);

@@ verif/lkr_replacer_checker.sv @@
// Scoreboard for the LRU-K frame replacer: predicts each result item from the
// accepted event items and the frames_in_use writes. Depends on lkr_pkg, lkr_ifs.
`timescale 1ns / 1ps
module lkr_replacer_checker (
  input  logic                              clk,
  input  logic                              rst,
  lkr_item_if                               req,
  lkr_result_if                             rsp,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic                              pready,
  input  logic [lkr_pkg::APB_ADDR_BITS-1:0] paddr,
  input  logic [lkr_pkg::APB_DATA_BITS-1:0] pwdata,
  output int                                fail_count,
  output int                                outstanding
);
  import lkr_pkg::*;

  localparam int NF = FRAME_SLOTS_DEF;
  localparam int HD = HISTORY_DEPTH_DEF;
  localparam logic [STAMP_BITS_DEF-1:0] STAMP_TOP = '1;

  typedef struct packed {
    status_t                   status;
    logic [VICTIM_BITS-1:0]    victim;
    logic [COUNT_OUT_BITS-1:0] evict_cnt;
  } verdict_t;

  logic [CFG_BITS-1:0]       frame_limit;
  logic                      tracked   [NF];
  logic                      evictable [NF];
  int                        hist_len  [NF];
  logic [STAMP_BITS_DEF-1:0] stamps    [NF][HD];
  logic [STAMP_BITS_DEF-1:0] stamp_clock;
  int                        evict_total;
  verdict_t                  awaited_q[$];

  task automatic drop(input int f);
    if (evictable[f] && evict_total > 0) evict_total--;
    tracked[f]   = 1'b0;
    evictable[f] = 1'b0;
    hist_len[f]  = 0;
  endtask

  // Work out the result of one event and advance the replacer state.
  task automatic predict_replacement(input mode_t m, input logic [FRAME_BITS-1:0] fr,
                                     input logic flag);
    int                        lim;
    int                        f;
    int                        short_f;
    int                        full_f;
    bit                        have_short;
    bit                        have_full;
    logic [STAMP_BITS_DEF-1:0] s;
    logic [STAMP_BITS_DEF-1:0] short_s;
    logic [STAMP_BITS_DEF-1:0] full_s;
    verdict_t                  v;
    lim = (int'(frame_limit) < NF) ? int'(frame_limit) : NF;
    f = int'(fr);
    v.status = ST_OK;
    v.victim = '0;
    if (m == MODE_EVICT) begin
      have_short = 1'b0;
      have_full = 1'b0;
      short_f = 0;
      full_f = 0;
      short_s = '0;
      full_s = '0;
      for (int i = 0; i < NF; i++) begin
        if (!tracked[i] || !evictable[i]) continue;
        s = (hist_len[i] > 0) ? stamps[i][0] : '0;
        if (hist_len[i] < HD) begin
          if (!have_short || s < short_s) begin
            have_short = 1'b1;
            short_f = i;
            short_s = s;
          end
        end else if (!have_full || s < full_s) begin
          have_full = 1'b1;
          full_f = i;
          full_s = s;
        end
      end
      if (!have_short && !have_full) v.status = ST_NOTHING;
      else begin
        f = have_short ? short_f : full_f;
        drop(f);
        v.victim = f[VICTIM_BITS-1:0];
      end
    end else if (f >= lim) v.status = ST_RANGE;
    else if (m == MODE_ACCESS) begin
      if (!tracked[f]) begin
        tracked[f]   = 1'b1;
        evictable[f] = 1'b0;
        hist_len[f]  = 0;
      end
      if (hist_len[f] >= HD) begin
        for (int i = 1; i < HD; i++) stamps[f][i-1] = stamps[f][i];
        stamps[f][HD-1] = stamp_clock;
      end else begin
        stamps[f][hist_len[f]] = stamp_clock;
        hist_len[f]++;
      end
      if (stamp_clock != STAMP_TOP) stamp_clock++;
    end else if (!tracked[f]) v.status = ST_UNTRACKED;
    else if (m == MODE_SET_EVICTABLE) begin
      if (evictable[f] != flag) begin
        evictable[f] = flag;
        if (flag) evict_total++;
        else if (evict_total > 0) evict_total--;
      end
    end else if (!evictable[f]) v.status = ST_NOT_EVICTABLE;
    else drop(f);
    v.evict_cnt = evict_total[COUNT_OUT_BITS-1:0];
    awaited_q.push_back(v);
  endtask

  initial begin
    fail_count = 0;
    outstanding = 0;
    frame_limit = FRAMES_IN_USE_RST;
    stamp_clock = '0;
    evict_total = 0;
    for (int i = 0; i < NF; i++) begin
      tracked[i] = 1'b0;
      evictable[i] = 1'b0;
      hist_len[i] = 0;
    end
  end

  always @(posedge clk) begin
    verdict_t w;
    if (!rst) begin
      // Compare first: a result leaving at this edge belongs to an earlier item.
      if (rsp.valid && rsp.ready) begin
        if (awaited_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: unexpected result status=%0d victim=%0d count=%0d", $realtime,
                     rsp.status, rsp.victim_frame, rsp.evictable_count);
        end else begin
          w = awaited_q.pop_front();
          if (rsp.status !== w.status || rsp.victim_frame !== w.victim ||
              rsp.evictable_count !== w.evict_cnt) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: expected status=%0d victim=%0d count=%0d, got %0d %0d %0d",
                       $realtime, w.status, w.victim, w.evict_cnt, rsp.status,
                       rsp.victim_frame, rsp.evictable_count);
          end
        end
      end
      if (req.valid && req.ready)
        predict_replacement(mode_t'(req.mode), req.frame, req.evictable_flag);
      if (psel && penable && pwrite && pready && paddr == REG_FRAMES_IN_USE)
        frame_limit = pwdata[CFG_BITS-1:0];
      outstanding = awaited_q.size();
    end
  end

  final begin
    if (awaited_q.size() != 0) $display("results never delivered: %0d", awaited_q.size());
  end
endmodule

@@ verif/tb_lru_k_frame_replacer.sv @@
// Top of the LRU-K frame replacer testbench: clock, reset, event stimulus,
// frames_in_use writes and the verdict. Depends on lkr_pkg, lkr_ifs, the block
// and lkr_replacer_checker.
`timescale 1ns / 1ps
module tb_lru_k_frame_replacer;
  import lkr_pkg::*;

  // Worst case drain: one evict scan plus slack.
  localparam int SETTLE_CYCLES = FRAME_SLOTS_DEF + 20;

  logic                     clk;
  logic                     rst;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [APB_ADDR_BITS-1:0] paddr;
  logic [APB_DATA_BITS-1:0] pwdata;
  logic [APB_DATA_BITS-1:0] prdata;
  logic                     pready;
  int                       fail_count;
  int                       outstanding;
  int                       sent_items;
  bit                       gaps_on;
  bit                       long_hold_req;
  int                       cur_limit;

  lkr_item_if   req();
  lkr_result_if rsp();

  lru_k_frame_replacer u_dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rsp     (rsp),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  lkr_replacer_checker u_chk (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .rsp         (rsp),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Hard stop in case the block hangs.
  initial begin
    #5ms;
    $display("lru_k_frame_replacer: mismatch");
    $finish;
  end

  // Result side: random stall bursts, plus one long hold-off on request so the
  // block backs up and stalls its input.
  initial begin
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        rsp.ready = 1'b0;
        repeat (300) @(negedge clk);
        long_hold_req = 1'b0;
      end else if (gaps_on && $urandom_range(0, 3) == 0) begin
        rsp.ready = 1'b0;
        repeat ($urandom_range(1, 9)) @(negedge clk);
      end
      rsp.ready = 1'b1;
    end
  end

  // Offer one event item; hold it until the block takes it.
  task automatic send_event(input mode_t m, input logic [FRAME_BITS-1:0] f, input logic e);
    @(negedge clk);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      req.valid = 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    req.valid = 1'b1;
    req.mode = m;
    req.frame = f;
    req.evictable_flag = e;
    do @(posedge clk); while (!req.ready);
    sent_items++;
  endtask

  // Drain all results, let any scan finish, then write frames_in_use.
  task automatic set_frame_limit(input int value);
    @(negedge clk);
    req.valid = 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    psel = 1'b1;
    pwrite = 1'b1;
    paddr = REG_FRAMES_IN_USE;
    pwdata = APB_DATA_BITS'(value);
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    cur_limit = (value < FRAME_SLOTS_DEF) ? value : FRAME_SLOTS_DEF;
  endtask

  // Well-formed traffic on a small working set so frames reach full history
  // and evicts find victims; a tenth draws frames from the whole 8-bit range as noise.
  task automatic random_phase(input int n);
    int    r;
    int    ws;
    logic [FRAME_BITS-1:0] f;
    mode_t m;
    ws = (cur_limit > 12) ? 12 : cur_limit;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (ws == 0 || r < 10) f = FRAME_BITS'($urandom_range(0, 255));
      else if (r < 20) f = FRAME_BITS'($urandom_range(0, cur_limit - 1));
      else f = FRAME_BITS'($urandom_range(0, ws - 1));
      r = $urandom_range(0, 99);
      if (r < 40) m = MODE_ACCESS;
      else if (r < 68) m = MODE_SET_EVICTABLE;
      else if (r < 86) m = MODE_EVICT;
      else m = MODE_REMOVE;
      send_event(m, f, $urandom_range(0, 3) != 0);
    end
  endtask

  initial begin
    rst = 1'b1;
    gaps_on = 1'b0;
    long_hold_req = 1'b0;
    sent_items = 0;
    cur_limit = int'(FRAMES_IN_USE_RST);
    req.valid = 1'b0;
    req.mode = MODE_ACCESS;
    req.frame = '0;
    req.evictable_flag = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: extremes, every status, short- versus full-history victims.
    set_frame_limit(64);
    send_event(MODE_EVICT, 8'd0, 1'b0);            // nothing evictable
    send_event(MODE_ACCESS, 8'd0, 1'b0);
    send_event(MODE_ACCESS, 8'd63, 1'b1);
    send_event(MODE_ACCESS, 8'd64, 1'b0);          // just out of range
    send_event(MODE_SET_EVICTABLE, 8'd255, 1'b1);  // out of range
    send_event(MODE_SET_EVICTABLE, 8'd5, 1'b1);    // untracked
    send_event(MODE_REMOVE, 8'd5, 1'b0);           // untracked
    send_event(MODE_REMOVE, 8'd0, 1'b0);           // not evictable
    send_event(MODE_SET_EVICTABLE, 8'd0, 1'b1);
    send_event(MODE_SET_EVICTABLE, 8'd0, 1'b1);    // same mark, no change
    repeat (4) send_event(MODE_ACCESS, 8'd0, 1'b0);
    send_event(MODE_SET_EVICTABLE, 8'd63, 1'b1);
    send_event(MODE_EVICT, 8'd255, 1'b1);          // short history beats full
    send_event(MODE_EVICT, 8'd0, 1'b0);
    send_event(MODE_ACCESS, 8'd40, 1'b0);
    send_event(MODE_SET_EVICTABLE, 8'd40, 1'b1);
    send_event(MODE_SET_EVICTABLE, 8'd40, 1'b0);
    send_event(MODE_SET_EVICTABLE, 8'd40, 1'b1);
    // Lower the limit below a tracked frame: evict still sees it.
    set_frame_limit(7);
    send_event(MODE_ACCESS, 8'd40, 1'b0);          // now out of range
    send_event(MODE_REMOVE, 8'd40, 1'b0);
    send_event(MODE_EVICT, 8'd0, 1'b0);
    send_event(MODE_REMOVE, 8'd6, 1'b0);

    // Random phases across limit settings, extremes included.
    gaps_on = 1'b1;
    set_frame_limit(1);
    random_phase(80);
    set_frame_limit(127);
    random_phase(60);
    long_hold_req = 1'b1;                          // block backs up here
    random_phase(80);
    set_frame_limit(0);
    random_phase(30);
    set_frame_limit(5);
    random_phase(100);
    set_frame_limit(33);
    random_phase(80);
    // Pause the sender until every result is back, then carry on.
    @(negedge clk);
    req.valid = 1'b0;
    while (outstanding != 0) @(posedge clk);
    random_phase(100);
    set_frame_limit(64);
    random_phase(150);
    gaps_on = 1'b0;                                // closing stretch at full rate
    random_phase(150);

    @(negedge clk);
    req.valid = 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("covered %0d events over limits 64, 7, 1, 127, 0, 5, 33 with stalls",
             sent_items);
    if (fail_count == 0) begin
      $display("lru_k_frame_replacer: match");
    end else begin
      $display("failures: %0d", fail_count);
      $display("lru_k_frame_replacer: mismatch");
    end
    $finish;
  end
endmodule
